@@ design/trrb_pkg.sv @@
// trrb_pkg: shared types and constants for the timestamped replay ring buffer
// used by trrb_ctrl, trrb_dp, the top level and the port checker
package trrb_pkg;

  localparam int CNT_W  = 13;  // fill count, capacity, internal positions
  localparam int POS_W  = 12;
  localparam int TIME_W = 48;
  localparam int SEC_W  = 16;
  localparam int LIM_W  = 36;  // seconds_back * 1e6
  localparam int DIFF_W = 49;
  localparam int USEC_PER_SEC = 1000000;

  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_CLEAR     = 3'd1;
  localparam logic [2:0] CMD_READ_AT   = 3'd2;
  localparam logic [2:0] CMD_FIND_TIME = 3'd3;
  localparam logic [2:0] CMD_FIND_KEY  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  localparam logic [2:0] CFG_ADDR_CAPACITY = 3'd0;

  typedef struct packed {
    logic [2:0]        command;
    logic [TIME_W-1:0] entry_time;
    logic              key_flag;
    logic [7:0]        stream_id;
    logic [31:0]       packet_tag;
    logic [POS_W-1:0]  position;
    logic [TIME_W-1:0] now_time;
    logic [SEC_W-1:0]  seconds_back;
    logic              invert_match;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  result_position;
    logic [TIME_W-1:0] result_time;
    logic              result_key;
    logic [7:0]        result_stream;
    logic [31:0]       result_tag;
    logic [CNT_W-1:0]  fill_level;
  } out_item_t;

  // one ring slot
  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic              key;
    logic [7:0]        stream;
    logic [31:0]       tag;
  } slot_t;

  typedef enum logic [1:0] {
    OUT_ZERO   = 2'd0,
    OUT_ENTRY  = 2'd1,
    OUT_APPEND = 2'd2
  } out_kind_t;

  typedef struct packed {
    logic       capture;
    logic       append;
    logic       clear;
    logic       issue;
    logic       bis_step;
    logic       scan_step;
    logic       out_load;
    out_kind_t  kind;
    logic [1:0] status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       empty;
    logic       pos_bad;
    logic       bis_done;
    logic       scan_hit;
    logic       scan_end;
    logic       out_busy;
  } dp_stat_t;

endpackage

@@ design/trrb_dp.sv @@
// trrb_dp: ring storage, pointers, bisection bounds, scan index and output register
// depends on trrb_pkg
module trrb_dp #(
  parameter int DEPTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  trrb_pkg::in_item_t        in_data,
  input  trrb_pkg::ctrl_cmd_t       cmd,
  output trrb_pkg::dp_stat_t        stat,
  input  logic                      cfg_we,
  input  logic [trrb_pkg::CNT_W-1:0] cfg_value,
  output logic [trrb_pkg::CNT_W-1:0] cap_o,
  output logic                      out_valid,
  input  logic                      out_stall,
  output trrb_pkg::out_item_t       out_data
);
  import trrb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_MAX = (DEPTH > 8191) ? 8191 : DEPTH;
  localparam int SW = CNT_W + 1;

  slot_t mem [DEPTH];

  in_item_t         req_r;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt, pos_r;
  logic [LIM_W-1:0] lim_r;
  slot_t            rdata_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic [CNT_W-1:0] probe, mid, start, pos_inc;
  logic [SW-1:0]    sum, slot;
  logic [DIFF_W-1:0] age;
  logic             old_ok, same;
  logic [CNT_W-1:0] wp_inc;

  // configuration value with clamping
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      if (cfg_value == '0) cap_nxt = CNT_W'(1);
      else if (32'(cfg_value) > CAP_MAX) cap_nxt = CNT_W'(CAP_MAX);
      else cap_nxt = cfg_value;
    end
  end

  // probe position and its physical slot
  always_comb begin
    mid = lo_r + ((hi_r - lo_r) >> 1);
    case (req_r.command)
      CMD_FIND_TIME: probe = mid;
      CMD_FIND_KEY:  probe = idx_r;
      default:       probe = CNT_W'(req_r.position);
    endcase
    start = (cnt_r < cap_r) ? '0 : wp_r;
    sum   = SW'(start) + SW'(probe);
    slot  = (sum >= SW'(cap_r)) ? sum - SW'(cap_r) : sum;
  end

  // age test and keyframe match on the registered slot
  always_comb begin
    age    = {1'b0, req_r.now_time} - {1'b0, rdata_r.ts};
    old_ok = $signed(age) >= $signed(DIFF_W'(lim_r));
    same   = rdata_r.stream == req_r.stream_id;
    pos_inc = pos_r + CNT_W'(1);
  end

  always_comb begin
    stat.command  = req_r.command;
    stat.empty    = cnt_r == '0;
    stat.pos_bad  = CNT_W'(req_r.position) >= cnt_r;
    stat.bis_done = old_ok ? (lo_r == pos_r) : (hi_r == pos_r);
    stat.scan_hit = rdata_r.key && (req_r.invert_match ? !same : same);
    stat.scan_end = pos_inc >= cnt_r;
    stat.out_busy = out_valid_r && out_stall;
  end

  always_comb begin
    wp_inc = wp_r + CNT_W'(1);
    wp_nxt = wp_r;
    cnt_nxt = cnt_r;
    if (cmd.append) begin
      wp_nxt = (wp_inc == cap_r) ? '0 : wp_inc;
      if (cnt_r < cap_r) cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.clear || cfg_we) begin
      wp_nxt  = '0;
      cnt_nxt = '0;
    end
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    idx_nxt = idx_r;
    if (cmd.capture) begin
      lo_nxt  = '0;
      hi_nxt  = cnt_r;
      idx_nxt = CNT_W'(in_data.position);
    end
    if (cmd.bis_step) begin
      if (old_ok) lo_nxt = pos_r;
      else hi_nxt = pos_r;
    end
    if (cmd.scan_step) idx_nxt = pos_inc;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt = out_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_nxt = '0;
      out_nxt.status = cmd.status;
      out_nxt.fill_level = cnt_r;
      case (cmd.kind)
        OUT_ENTRY: begin
          out_nxt.result_position = POS_W'(pos_r);
          out_nxt.result_time   = rdata_r.ts;
          out_nxt.result_key    = rdata_r.key;
          out_nxt.result_stream = rdata_r.stream;
          out_nxt.result_tag    = rdata_r.tag;
        end
        OUT_APPEND: begin
          out_nxt.result_position = POS_W'(cnt_r - CNT_W'(1));
          out_nxt.result_time   = req_r.entry_time;
          out_nxt.result_key    = req_r.key_flag;
          out_nxt.result_stream = req_r.stream_id;
          out_nxt.result_tag    = req_r.packet_tag;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[AW'(wp_r)] <= '{ts: req_r.entry_time, key: req_r.key_flag,
                          stream: req_r.stream_id, tag: req_r.packet_tag};
    end
    if (cmd.issue) begin
      rdata_r <= mem[AW'(slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
      lim_r <= LIM_W'(in_data.seconds_back) * LIM_W'(USEC_PER_SEC);
    end
    if (cmd.issue) pos_r <= probe;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(CAP_MAX);
      wp_r  <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r <= cap_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cap_o     = cap_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/trrb_ctrl.sv @@
// trrb_ctrl: command sequencer for the replay ring
// depends on trrb_pkg; drives trrb_dp through ctrl_cmd_t
module trrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  trrb_pkg::dp_stat_t  stat,
  output trrb_pkg::ctrl_cmd_t cmd
);
  import trrb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_ISSUE    = 5'b00100,
    S_DECIDE   = 5'b01000,
    S_OUT      = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  out_kind_t  kind_r, kind_nxt;
  logic [1:0] st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    cmd.status = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_ISSUE;
        kind_nxt  = OUT_ZERO;
        st_nxt    = ST_OK;
        case (stat.command)
          CMD_APPEND: begin
            cmd.append = 1'b1;
            kind_nxt = OUT_APPEND;
            state_nxt = S_OUT;
          end
          CMD_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_OUT;
          end
          CMD_READ_AT, CMD_FIND_KEY: begin
            if (stat.pos_bad) begin
              st_nxt = ST_RANGE;
              state_nxt = S_OUT;
            end
          end
          CMD_FIND_TIME: begin
            if (stat.empty) begin
              st_nxt = ST_NOT_FOUND;
              state_nxt = S_OUT;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        kind_nxt  = OUT_ENTRY;
        state_nxt = S_OUT;
        if (stat.command == CMD_FIND_TIME) begin
          cmd.bis_step = 1'b1;
          if (!stat.bis_done) state_nxt = S_ISSUE;
        end else if (stat.command == CMD_FIND_KEY && !stat.scan_hit) begin
          if (stat.scan_end) begin
            kind_nxt = OUT_ZERO;
            st_nxt   = ST_NOT_FOUND;
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= OUT_ZERO;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

@@ design/timestamped_replay_ring_buffer_top.sv @@
// timestamped_replay_ring_buffer_top: ring of packet descriptors with search
// depends on trrb_pkg, trrb_ctrl, trrb_dp
//
// usage:
//   in_* channel carries one request (append, clear, read_at, find_by_time,
//   find_keyframe); out_* channel returns exactly one result per request.
//   a request is taken when valid is high and stall is low.
//   the cfg_* apb port holds the capacity register at address 0; writing it
//   empties the ring. write it only while no request is in flight.
// sequencing:
//   append, clear, range errors and unused commands go from dispatch straight
//   to the result. read_at reads one slot. each probe of the bisection or each
//   slot of the keyframe scan is a slot address step, then the registered memory
//   read; find_by_time probes until the bisection bounds meet and find_keyframe
//   scans up from position until a keyframe matches or the fill is reached.
//   one request is in work at a time; the next is accepted while the last
//   result still sits in the output register.
// reset: pointer and fill count go to zero, capacity to DEPTH (at most 8191);
//   slot contents are not cleared. a stalled result holds until taken; the
//   sequencer waits for the output register before loading the next result.
module timestamped_replay_ring_buffer_top #(
  parameter int DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  trrb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output trrb_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import trrb_pkg::*;

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic             cfg_we;
  logic [CNT_W-1:0] cap;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == CFG_ADDR_CAPACITY);
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_CAPACITY) ? 32'(cap) : '0;

  trrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  trrb_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_value (cfg_pwdata[CNT_W-1:0]),
    .cap_o     (cap),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/trrb_checker.sv @@
// trrb_checker: port-level checks for timestamped_replay_ring_buffer_top
// depends on trrb_pkg; bound to the top level below
module trrb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input trrb_pkg::out_item_t out_data
);
  import trrb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_RANGE)
    else $error("undefined status code");

  // error results carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.result_position == '0 && out_data.result_time == '0 &&
      out_data.result_tag == '0)
    else $error("error result carries entry data");

  // nonzero position implies more entries than that position
  a_pos_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> CNT_W'(out_data.result_position) < out_data.fill_level ||
      out_data.result_position == '0)
    else $error("position beyond fill level");

endmodule

bind timestamped_replay_ring_buffer_top trrb_checker u_trrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/tb.sv @@
// tb: self-checking bench for timestamped_replay_ring_buffer_top, with an in-bench ring
// predictor and random request and result stalls; needs trrb_pkg and the design
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import trrb_pkg::*;

  localparam int RING_DEPTH = 4096;
  localparam int WATCHDOG_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  timestamped_replay_ring_buffer_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // ring mirror
  logic [TIME_W-1:0] ring_time [RING_DEPTH];
  logic ring_key [RING_DEPTH];
  logic [7:0] ring_stream [RING_DEPTH];
  logic [31:0] ring_tag [RING_DEPTH];
  int ring_wp = 0;
  int ring_count = 0;
  int ring_cap = RING_DEPTH;

  in_item_t request_q[$];
  out_item_t result_q[$];
  int err_cnt = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  bit quiet = 0;
  bit accept_seen;
  int idle_cycles = 0;
  logic [TIME_W-1:0] tgen = '0;

  function automatic int ring_slot(int pos);
    int start;
    start = (ring_count < ring_cap) ? 0 : ring_wp;
    return (start + pos) % ring_cap;
  endfunction

  function automatic bit old_enough(int pos, logic [TIME_W-1:0] now, logic [SEC_W-1:0] secs);
    longint age;
    longint lim;
    age = longint'({16'b0, now}) - longint'({16'b0, ring_time[ring_slot(pos)]});
    lim = longint'({48'b0, secs}) * USEC_PER_SEC;
    return age >= lim;
  endfunction

  function automatic out_item_t entry_result(int pos);
    out_item_t r;
    int s;
    s = ring_slot(pos);
    r = '0;
    r.status = ST_OK;
    r.result_position = pos[POS_W-1:0];
    r.result_time = ring_time[s];
    r.result_key = ring_key[s];
    r.result_stream = ring_stream[s];
    r.result_tag = ring_tag[s];
    return r;
  endfunction

  task automatic predict_request(in_item_t it);
    out_item_t r;
    int pos, lo, hi, mid, w;
    bit same;
    r = '0;
    pos = int'(it.position);
    case (it.command)
      CMD_APPEND: begin
        w = ring_wp % ring_cap;
        ring_time[w] = it.entry_time;
        ring_key[w] = it.key_flag;
        ring_stream[w] = it.stream_id;
        ring_tag[w] = it.packet_tag;
        ring_wp = (w + 1) % ring_cap;
        if (ring_count < ring_cap) ring_count++;
        r = entry_result(ring_count - 1);
      end
      CMD_CLEAR: begin
        ring_wp = 0;
        ring_count = 0;
      end
      CMD_READ_AT: begin
        if (pos >= ring_count) r.status = ST_RANGE;
        else r = entry_result(pos);
      end
      CMD_FIND_TIME: begin
        if (ring_count == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          lo = 0;
          hi = ring_count;
          forever begin
            mid = lo + (hi - lo) / 2;
            if (old_enough(mid, it.now_time, it.seconds_back)) begin
              if (lo == mid) break;
              lo = mid;
            end else begin
              if (hi == mid) break;
              hi = mid;
            end
          end
          r = entry_result(mid);
        end
      end
      CMD_FIND_KEY: begin
        if (pos >= ring_count) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_NOT_FOUND;
          for (int i = pos; i < ring_count; i++) begin
            same = ring_stream[ring_slot(i)] == it.stream_id;
            if (ring_key[ring_slot(i)] && (it.invert_match ? !same : same)) begin
              r = entry_result(i);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.fill_level = ring_count[CNT_W-1:0];
    result_q.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    bit nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_request(in_data);
        nxt_valid = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0 && !quiet) begin
          in_gap--;
          nxt_valid = 1'b0;
        end else if (request_q.size() > 0) begin
          nxt_data = request_q.pop_front();
          nxt_valid = 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h actual %h", $time, name, e, a);
      err_cnt++;
    end
  endfunction

  // result monitor and stall generator
  always @(posedge clk) begin
    out_item_t e;
    bit nxt_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_data);
        err_cnt++;
      end else begin
        e = result_q.pop_front();
        check_field("status", e.status, out_data.status);
        check_field("result_position", e.result_position, out_data.result_position);
        check_field("result_time", e.result_time, out_data.result_time);
        check_field("result_key", e.result_key, out_data.result_key);
        check_field("result_stream", e.result_stream, out_data.result_stream);
        check_field("result_tag", e.result_tag, out_data.result_tag);
        check_field("fill_level", e.fill_level, out_data.fill_level);
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    nxt_stall = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      nxt_stall = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 10);
      nxt_stall = 1'b1;
    end
    out_stall <= nxt_stall;
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    accept_seen = (in_valid && !in_stall) || (out_valid && !out_stall);
    idle_cycles = accept_seen ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    int v;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_ADDR_CAPACITY;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    v = int'(value[CNT_W-1:0]);
    if (v == 0) v = 1;
    if (v > RING_DEPTH) v = RING_DEPTH;
    ring_cap = v;
    ring_wp = 0;
    ring_count = 0;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t rand_request();
    in_item_t it;
    int pick;
    it.command = CMD_APPEND;
    it.entry_time = rand_time();
    it.key_flag = 1'($urandom_range(0, 1));
    it.stream_id = 8'($urandom);
    it.packet_tag = $urandom;
    it.position = POS_W'($urandom);
    it.now_time = rand_time();
    it.seconds_back = SEC_W'($urandom);
    it.invert_match = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 50) it.command = CMD_APPEND;
    else if (pick < 68) it.command = CMD_READ_AT;
    else if (pick < 81) it.command = CMD_FIND_TIME;
    else if (pick < 94) it.command = CMD_FIND_KEY;
    else if (pick < 97) it.command = CMD_CLEAR;
    else it.command = 3'($urandom_range(5, 7));
    // mostly well-formed: rising timestamps, nearby positions, few streams
    if ($urandom_range(0, 9) != 0) begin
      tgen = tgen + 48'($urandom_range(0, 3000000));
      it.entry_time = tgen;
      it.now_time = tgen + 48'($urandom_range(0, 6000000));
      it.seconds_back = SEC_W'($urandom_range(0, 5));
      it.position = POS_W'($urandom_range(0, 40));
      it.stream_id = 8'($urandom_range(0, 3));
    end
    return it;
  endfunction

  function automatic in_item_t make_request(logic [2:0] cmd, logic [TIME_W-1:0] t,
                                             logic key, logic [7:0] sid, logic [31:0] tag,
                                             logic [POS_W-1:0] pos, logic [SEC_W-1:0] secs,
                                             logic inv);
    in_item_t it;
    it.command = cmd;
    it.entry_time = t;
    it.key_flag = key;
    it.stream_id = sid;
    it.packet_tag = tag;
    it.position = pos;
    it.now_time = t;
    it.seconds_back = secs;
    it.invert_match = inv;
    return it;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) request_q.push_back(rand_request());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, unused commands, field extremes, searches
    request_q.push_back(make_request(CMD_READ_AT, '0, 0, 0, 0, 0, 0, 0));
    request_q.push_back(make_request(CMD_FIND_TIME, '0, 0, 0, 0, 0, 0, 0));
    request_q.push_back(make_request(CMD_FIND_KEY, '0, 0, 0, 0, 0, 0, 0));
    request_q.push_back(make_request(3'd5, '1, 1, 8'hff, '1, '1, '1, 1));
    request_q.push_back(make_request(3'd6, '0, 0, 0, 0, 0, 0, 0));
    request_q.push_back(make_request(3'd7, '1, 1, 8'hff, '1, '1, '1, 1));
    request_q.push_back(make_request(CMD_APPEND, '0, 0, 8'h00, 32'h0, 0, 0, 0));
    request_q.push_back(make_request(CMD_APPEND, 48'd5000000, 1, 8'h01, 32'h1234, 0, 0, 0));
    request_q.push_back(make_request(CMD_APPEND, 48'd9000000, 1, 8'hff, '1, '1, 0, 0));
    request_q.push_back(make_request(CMD_APPEND, '1, 1, 8'h01, 32'h5555, 0, 0, 0));
    request_q.push_back(make_request(CMD_READ_AT, '0, 0, 0, 0, 12'd0, 0, 0));
    request_q.push_back(make_request(CMD_READ_AT, '0, 0, 0, 0, 12'd3, 0, 0));
    request_q.push_back(make_request(CMD_READ_AT, '0, 0, 0, 0, 12'd4, 0, 0));
    request_q.push_back(make_request(CMD_READ_AT, '0, 0, 0, 0, '1, 0, 0));
    request_q.push_back(make_request(CMD_FIND_TIME, 48'd10000000, 0, 0, 0, 0, 16'd5, 0));
    request_q.push_back(make_request(CMD_FIND_TIME, 48'd10000000, 0, 0, 0, 0, '1, 0));
    request_q.push_back(make_request(CMD_FIND_TIME, '1, 0, 0, 0, 0, 16'd0, 0));
    request_q.push_back(make_request(CMD_FIND_KEY, '0, 0, 8'h01, 0, 12'd0, 0, 0));
    request_q.push_back(make_request(CMD_FIND_KEY, '0, 0, 8'h01, 0, 12'd2, 0, 1));
    request_q.push_back(make_request(CMD_FIND_KEY, '0, 0, 8'h42, 0, 12'd0, 0, 0));
    request_q.push_back(make_request(CMD_FIND_KEY, '0, 0, 8'h00, 0, '1, 0, 1));
    request_q.push_back(make_request(CMD_CLEAR, '1, 1, 8'hff, '1, '1, '1, 1));
    request_q.push_back(make_request(CMD_APPEND, 48'd7, 1, 8'h02, 32'h77, 0, 0, 0));
    request_q.push_back(make_request(CMD_READ_AT, '0, 0, 0, 0, 12'd0, 0, 0));
    wait_drained();

    write_capacity(32'd0);  // taken as one slot
    run_random(60);
    wait_drained();

    write_capacity(32'h1fff);  // saturates to full depth
    run_random(70);
    wait_drained();  // sender pause until all results are back
    run_random(70);
    wait_drained();

    write_capacity(32'd5);
    run_random(40);
    hold_req++;  // long receiver hold-off while requests keep coming
    run_random(110);
    wait_drained();

    write_capacity(32'd4096);
    run_random(130);
    wait_drained();

    write_capacity(32'd17);
    run_random(60);
    wait_drained();
    quiet = 1;
    run_random(60);
    wait_drained();

    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
